// File: rtl/acr_pkg.sv
`default_nettype none

package acr_pkg;

   localparam int IP_W  = 32;
   localparam int MAC_W = 48;
   localparam int LS_W  = 2;

   // Request kinds.
   localparam logic REQ_LEARN   = 1'b0;
   localparam logic REQ_RESOLVE = 1'b1;

   // Learn status codes.
   localparam logic [LS_W-1:0] LS_FULL    = 2'd0;
   localparam logic [LS_W-1:0] LS_UPDATED = 2'd1;
   localparam logic [LS_W-1:0] LS_NEW     = 2'd2;

   localparam logic [IP_W-1:0]  BCAST_IP     = 32'hFFFF_FFFF;
   localparam logic [MAC_W-1:0] MAC_ALL_ONES = 48'hFFFF_FFFF_FFFF;
   localparam logic [IP_W-1:0]  OWN_IP_RESET = 32'h0A00_020F;

   typedef struct packed {
      logic             req_type;
      logic [IP_W-1:0]  query_ip;
      logic [MAC_W-1:0] sender_mac;
      logic [IP_W-1:0]  asked_ip;
      logic             is_request;
   } item_type;

   typedef struct packed {
      logic             hit;
      logic [MAC_W-1:0] found_mac;
      logic [LS_W-1:0]  learn_status;
      logic             reply_needed;
   } result_type;

   typedef struct packed {
      logic [IP_W-1:0]  ip;
      logic [MAC_W-1:0] mac;
   } entry_type;

   typedef struct packed {
      logic idle;
      logic finish;
   } seq_status_type;

endpackage

`default_nettype wire

// File: rtl/acr_ifs.sv
`default_nettype none

interface acr_req_if;
   logic                     valid;
   logic                     ready;
   logic                     req_type;
   logic [acr_pkg::IP_W-1:0]  query_ip;
   logic [acr_pkg::MAC_W-1:0] sender_mac;
   logic [acr_pkg::IP_W-1:0]  asked_ip;
   logic                     is_request;

   modport source (output valid, req_type, query_ip, sender_mac, asked_ip, is_request,
                   input ready);
   modport sink (input valid, req_type, query_ip, sender_mac, asked_ip, is_request,
                 output ready);
endinterface

interface acr_rsp_if;
   logic                      valid;
   logic                      ready;
   logic                      hit;
   logic [acr_pkg::MAC_W-1:0] found_mac;
   logic [acr_pkg::LS_W-1:0]  learn_status;
   logic                      reply_needed;

   modport source (output valid, hit, found_mac, learn_status, reply_needed,
                   input ready);
   modport sink (input valid, hit, found_mac, learn_status, reply_needed,
                 output ready);
endinterface

`default_nettype wire

// File: rtl/acr_store.sv
`default_nettype none

module acr_store #(
   parameter int ENTRIES = 32
) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [$clog2(ENTRIES)-1:0] wr_addr,
   input  wire acr_pkg::entry_type         wr_entry,
   input  wire logic [$clog2(ENTRIES)-1:0] rd_addr,
   output      acr_pkg::entry_type         rd_entry
);

   acr_pkg::entry_type mem [ENTRIES];
   acr_pkg::entry_type rd_entry_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_entry;
      end
      rd_entry_ff <= mem[rd_addr];
   end

   assign rd_entry = rd_entry_ff;

endmodule

`default_nettype wire

// File: rtl/acr_seq.sv
`default_nettype none

module acr_seq #(
   parameter int ENTRIES = 32
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire acr_pkg::item_type             item,
   input  wire logic [acr_pkg::IP_W-1:0]      own_ip,
   input  wire logic                          out_free,
   output      acr_pkg::seq_status_type       status,
   output      acr_pkg::result_type           result,
   output      logic                          wr_en,
   output      logic [$clog2(ENTRIES)-1:0]    wr_addr,
   output      acr_pkg::entry_type            wr_entry,
   output      logic [$clog2(ENTRIES)-1:0]    rd_addr,
   input  wire acr_pkg::entry_type            rd_entry
);

   localparam int IDX_W = $clog2(ENTRIES);
   localparam int CNT_W = $clog2(ENTRIES + 1);

   typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FINISH} state_type;

   state_type           state_ff, state_in;
   acr_pkg::item_type   item_ff, item_in;
   acr_pkg::result_type res_ff, res_in;
   logic [CNT_W-1:0]    fill_cnt_ff, fill_cnt_in;
   logic [CNT_W-1:0]    scan_idx_ff, scan_idx_in;
   logic [CNT_W-1:0]    cmp_idx_ff, cmp_idx_in;
   logic                cmp_vld_ff, cmp_vld_in;
   logic                issue;
   logic                match;

   // Valid entries always form a prefix, so the fill count stands in for valid bits.
   assign issue = scan_idx_ff < fill_cnt_ff;
   assign match = rd_entry.ip == item_ff.query_ip;
   assign rd_addr = scan_idx_ff[IDX_W-1:0];

   always_comb begin
      state_in    = state_ff;
      item_in     = item_ff;
      res_in      = res_ff;
      fill_cnt_in = fill_cnt_ff;
      scan_idx_in = scan_idx_ff;
      cmp_idx_in  = cmp_idx_ff;
      cmp_vld_in  = 1'b0;
      wr_en       = 1'b0;
      wr_addr     = cmp_idx_ff[IDX_W-1:0];
      wr_entry.ip  = item_ff.query_ip;
      wr_entry.mac = item_ff.sender_mac;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               item_in = item;
               res_in = '0;
               res_in.reply_needed = (item.req_type == acr_pkg::REQ_LEARN) &&
                                     item.is_request && (item.asked_ip == own_ip);
               scan_idx_in = '0;
               if ((item.req_type == acr_pkg::REQ_RESOLVE) &&
                   (item.query_ip == acr_pkg::BCAST_IP)) begin
                  res_in.hit       = 1'b1;
                  res_in.found_mac = acr_pkg::MAC_ALL_ONES;
                  state_in         = ST_FINISH;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            // Reads are issued one per cycle; the compare works one entry behind.
            cmp_vld_in = issue;
            cmp_idx_in = scan_idx_ff;
            if (issue) begin
               scan_idx_in = scan_idx_ff + CNT_W'(1);
            end
            if (cmp_vld_ff && match) begin
               cmp_vld_in = 1'b0;
               state_in   = ST_FINISH;
               if (item_ff.req_type == acr_pkg::REQ_RESOLVE) begin
                  res_in.hit       = 1'b1;
                  res_in.found_mac = rd_entry.mac;
               end else begin
                  wr_en               = 1'b1;
                  wr_addr             = cmp_idx_ff[IDX_W-1:0];
                  res_in.learn_status = acr_pkg::LS_UPDATED;
               end
            end else if (!cmp_vld_ff && !issue) begin
               state_in = ST_FINISH;
               if ((item_ff.req_type == acr_pkg::REQ_LEARN) &&
                   (fill_cnt_ff < CNT_W'(ENTRIES))) begin
                  wr_en               = 1'b1;
                  wr_addr             = fill_cnt_ff[IDX_W-1:0];
                  res_in.learn_status = acr_pkg::LS_NEW;
                  fill_cnt_in         = fill_cnt_ff + CNT_W'(1);
               end
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         fill_cnt_ff <= '0;
         cmp_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         fill_cnt_ff <= fill_cnt_in;
         cmp_vld_ff  <= cmp_vld_in;
      end
      item_ff     <= item_in;
      res_ff      <= res_in;
      scan_idx_ff <= scan_idx_in;
      cmp_idx_ff  <= cmp_idx_in;
   end

   assign status.idle   = state_ff == ST_IDLE;
   assign status.finish = state_ff == ST_FINISH;
   assign result        = res_ff;

`ifndef SYNTHESIS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_cnt_ff <= CNT_W'(ENTRIES))
      else $error("fill count beyond the number of entries");

   a_write_ends_scan: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> state_ff == ST_FINISH)
      else $error("store written without finishing the item");

   a_cmp_in_scan: assert property (@(posedge clock) disable iff (reset)
      cmp_vld_ff |-> state_ff == ST_SCAN)
      else $error("compare stage active outside the scan");

   a_full_only_when_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH) && (item_ff.req_type == acr_pkg::REQ_LEARN) &&
      (res_ff.learn_status == acr_pkg::LS_FULL) |-> fill_cnt_ff == CNT_W'(ENTRIES))
      else $error("learn reported full while entries were free");
`endif

endmodule

`default_nettype wire

// File: rtl/arp_cache_learn_resolve_unit.sv
// Channel   Direction  Handshake      Word
// req_if    in         valid/ready    req_type, query_ip, sender_mac, asked_ip, is_request
// rsp_if    out        valid/ready    hit, found_mac, learn_status, reply_needed
// csr       in         csr_wr_en      csr_wr_data (own IP address)
//
// A broadcast resolve goes straight to the finish state; any other item first scans the filled
// entries through the single read port of the entry store, one entry per cycle. The sequencer
// returns to idle for the next word at the same edge that registers the result.
// Reset is synchronous; a fill count marks the valid entries, so no clearing pass is needed.
// Up to two words in flight; a stalled result holds the sequencer in its finish state.
`default_nettype none

module arp_cache_learn_resolve_unit #(
   parameter int ENTRIES = 32
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   acr_req_if.sink                       req_if,
   acr_rsp_if.source                     rsp_if,
   input  wire logic                     csr_wr_en,
   input  wire logic [acr_pkg::IP_W-1:0] csr_wr_data
);

   localparam int IDX_W = $clog2(ENTRIES);

   logic [acr_pkg::IP_W-1:0] own_ip_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   acr_pkg::result_type      rsp_data_ff, rsp_data_in;

   acr_pkg::item_type        item;
   acr_pkg::result_type      result;
   acr_pkg::seq_status_type  status;
   acr_pkg::entry_type       wr_entry;
   acr_pkg::entry_type       rd_entry;
   logic                     wr_en;
   logic [IDX_W-1:0]         wr_addr;
   logic [IDX_W-1:0]         rd_addr;
   logic                     out_free;
   logic                     start;

   assign item.req_type   = req_if.req_type;
   assign item.query_ip   = req_if.query_ip;
   assign item.sender_mac = req_if.sender_mac;
   assign item.asked_ip   = req_if.asked_ip;
   assign item.is_request = req_if.is_request;

   assign req_if.ready = status.idle;
   assign start        = req_if.valid && status.idle;
   assign out_free     = !rsp_valid_ff || rsp_if.ready;

   acr_seq #(.ENTRIES(ENTRIES)) u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .item     (item),
      .own_ip   (own_ip_ff),
      .out_free (out_free),
      .status   (status),
      .result   (result),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_entry (wr_entry),
      .rd_addr  (rd_addr),
      .rd_entry (rd_entry)
   );

   acr_store #(.ENTRIES(ENTRIES)) u_store (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_entry (wr_entry),
      .rd_addr  (rd_addr),
      .rd_entry (rd_entry)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (status.finish && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         own_ip_ff    <= acr_pkg::OWN_IP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            own_ip_ff <= csr_wr_data;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.hit          = rsp_data_ff.hit;
   assign rsp_if.found_mac    = rsp_data_ff.found_mac;
   assign rsp_if.learn_status = rsp_data_ff.learn_status;
   assign rsp_if.reply_needed = rsp_data_ff.reply_needed;

endmodule

`default_nettype wire

// File: sim/tb.sv
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CACHE_DEPTH = 32;
   localparam int POOL_SIZE   = 40;
   localparam int POOL_IDX_W  = $clog2(POOL_SIZE);
   localparam int PHASE_ITEMS = 86;
   localparam int LONG_HOLD   = 300;
   localparam int CYCLE_LIMIT = 400000;

   // Shadow copy of the cache: predicts one answer word per accepted request word.
   class cache_shadow;
      logic [acr_pkg::IP_W-1:0]  own_ip;
      logic [acr_pkg::IP_W-1:0]  slot_ip[CACHE_DEPTH];
      logic [acr_pkg::MAC_W-1:0] slot_mac[CACHE_DEPTH];
      bit                        slot_used[CACHE_DEPTH];
      acr_pkg::result_type       answers[$];
      int                        mismatches;
      int                        words_seen;

      function new();
         own_ip = acr_pkg::OWN_IP_RESET;
         foreach (slot_used[i]) begin
            slot_ip[i]   = '0;
            slot_mac[i]  = '0;
            slot_used[i] = 1'b0;
         end
         mismatches = 0;
         words_seen = 0;
      endfunction

      function void take_request(acr_pkg::item_type it);
         acr_pkg::result_type ans;
         ans = '0;
         if (it.req_type == acr_pkg::REQ_RESOLVE) begin
            if (it.query_ip == acr_pkg::BCAST_IP) begin
               ans.hit       = 1'b1;
               ans.found_mac = acr_pkg::MAC_ALL_ONES;
            end else begin
               for (int i = 0; i < CACHE_DEPTH; i++) begin
                  if (slot_used[i] && slot_ip[i] == it.query_ip) begin
                     ans.hit       = 1'b1;
                     ans.found_mac = slot_mac[i];
                     break;
                  end
               end
            end
         end else begin
            ans.learn_status = acr_pkg::LS_FULL;
            for (int i = 0; i < CACHE_DEPTH; i++) begin
               if (!slot_used[i] || slot_ip[i] == it.query_ip) begin
                  ans.learn_status = slot_used[i] ? acr_pkg::LS_UPDATED : acr_pkg::LS_NEW;
                  slot_ip[i]   = it.query_ip;
                  slot_mac[i]  = it.sender_mac;
                  slot_used[i] = 1'b1;
                  break;
               end
            end
            ans.reply_needed = it.is_request && (it.asked_ip == own_ip);
         end
         answers.push_back(ans);
      endfunction

      task report(string msg);
         $display("ERROR at %0t: %s", $realtime, msg);
         mismatches++;
      endtask

      task check_answer(acr_pkg::result_type got);
         acr_pkg::result_type want;
         words_seen++;
         if (answers.size() == 0) begin
            report($sformatf("answer word %0d arrived with nothing expected: %h",
                             words_seen, got));
            return;
         end
         want = answers.pop_front();
         if (got.hit !== want.hit)
            report($sformatf("word %0d hit %b, expected %b", words_seen, got.hit, want.hit));
         if (got.found_mac !== want.found_mac)
            report($sformatf("word %0d found_mac %h, expected %h",
                             words_seen, got.found_mac, want.found_mac));
         if (got.learn_status !== want.learn_status)
            report($sformatf("word %0d learn_status %0d, expected %0d",
                             words_seen, got.learn_status, want.learn_status));
         if (got.reply_needed !== want.reply_needed)
            report($sformatf("word %0d reply_needed %b, expected %b",
                             words_seen, got.reply_needed, want.reply_needed));
      endtask

      task close_out();
         if (answers.size() != 0)
            report($sformatf("%0d answer words never arrived", answers.size()));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic [acr_pkg::IP_W-1:0] csr_wr_data;

   acr_req_if req_if ();
   acr_rsp_if rsp_if ();

   arp_cache_learn_resolve_unit #(
      .ENTRIES(CACHE_DEPTH)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .rsp_if     (rsp_if),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   cache_shadow              shadow;
   logic [acr_pkg::IP_W-1:0] ip_pool[POOL_SIZE];
   int                       burst_left = 0;
   bit                       hold_rsp = 1'b0;
   int                       cycles = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("arp_cache_learn_resolve_unit: mismatch");
         $finish;
      end
   end

   // Request words are noted before answers so that a word's own answer never overtakes it.
   always @(posedge clock) begin
      if (!reset && shadow != null) begin
         if (req_if.valid && req_if.ready)
            shadow.take_request(acr_pkg::item_type'({req_if.req_type, req_if.query_ip,
                                                     req_if.sender_mac, req_if.asked_ip,
                                                     req_if.is_request}));
         if (rsp_if.valid && rsp_if.ready)
            shadow.check_answer(acr_pkg::result_type'({rsp_if.hit, rsp_if.found_mac,
                                                       rsp_if.learn_status,
                                                       rsp_if.reply_needed}));
      end
   end

   // Receiver: one of four stall styles, drawn anew at random; a long hold-off on request.
   initial begin
      int cyc = 0;
      int mode = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         cyc++;
         if (hold_rsp) begin
            rsp_if.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_rsp = 1'b0;
         end else begin
            if (cyc % 64 == 0)
               mode = $urandom_range(0, 3);
            case (mode)
               0: begin
                  rsp_if.ready <= 1'b1;
               end
               1: begin
                  rsp_if.ready <= 1'($urandom_range(0, 1));
               end
               2: begin
                  rsp_if.ready <= (cyc % 4 == 0);
               end
               default: begin
                  rsp_if.ready <= ($urandom_range(0, 9) != 0);
               end
            endcase
         end
      end
   end

   function automatic acr_pkg::item_type make_item(logic kind,
                                                   logic [acr_pkg::IP_W-1:0] ip,
                                                   logic [acr_pkg::MAC_W-1:0] mac,
                                                   logic [acr_pkg::IP_W-1:0] asked,
                                                   logic req);
      acr_pkg::item_type it;
      it.req_type   = kind;
      it.query_ip   = ip;
      it.sender_mac = mac;
      it.asked_ip   = asked;
      it.is_request = req;
      return it;
   endfunction

   // Mostly addresses from a pool slightly larger than the cache, so entries get
   // updated, resolves hit, and the cache eventually runs full.
   function automatic acr_pkg::item_type random_item();
      acr_pkg::item_type it;
      int pick;
      pick          = $urandom_range(0, 99);
      it.req_type   = $urandom_range(0, 1) ? acr_pkg::REQ_RESOLVE : acr_pkg::REQ_LEARN;
      it.sender_mac = {16'($urandom()), 32'($urandom())};
      it.asked_ip   = ($urandom_range(0, 3) == 0) ? shadow.own_ip : 32'($urandom());
      it.is_request = 1'($urandom_range(0, 1));
      if (pick < 70)
         it.query_ip = ip_pool[POOL_IDX_W'($urandom_range(0, POOL_SIZE - 1))];
      else if (pick < 80)
         it.query_ip = acr_pkg::BCAST_IP;
      else
         it.query_ip = $urandom();
      return it;
   endfunction

   task automatic offer(input acr_pkg::item_type it);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_if.valid      <= 1'b1;
      req_if.req_type   <= it.req_type;
      req_if.query_ip   <= it.query_ip;
      req_if.sender_mac <= it.sender_mac;
      req_if.asked_ip   <= it.asked_ip;
      req_if.is_request <= it.is_request;
      do @(posedge clock); while (!req_if.ready);
   endtask

   // The last accepted word is noted at its own edge, so the count is looked at only after the next edge.
   task automatic drain();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (shadow.answers.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   task automatic write_own_ip(input logic [acr_pkg::IP_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      shadow.own_ip = value;
   endtask

   initial begin
      logic [acr_pkg::IP_W-1:0] phase_ip[5];
      shadow = new();
      foreach (ip_pool[i])
         ip_pool[i] = $urandom();
      phase_ip = '{acr_pkg::OWN_IP_RESET, 32'h0, 32'hFFFF_FFFF, 32'h0, acr_pkg::OWN_IP_RESET};
      phase_ip[3] = $urandom();

      reset             <= 1'b1;
      csr_wr_en         <= 1'b0;
      csr_wr_data       <= '0;
      req_if.valid      <= 1'b0;
      req_if.req_type   <= acr_pkg::REQ_LEARN;
      req_if.query_ip   <= '0;
      req_if.sender_mac <= '0;
      req_if.asked_ip   <= '0;
      req_if.is_request <= 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Empty cache: an address of zero must miss, broadcast must still hit.
      offer(make_item(acr_pkg::REQ_RESOLVE, 32'h0, acr_pkg::MAC_ALL_ONES, 32'hFFFF_FFFF, 1'b1));
      offer(make_item(acr_pkg::REQ_RESOLVE, acr_pkg::BCAST_IP, 48'h0, 32'h0, 1'b0));
      offer(make_item(acr_pkg::REQ_LEARN, 32'h0, 48'h0, acr_pkg::OWN_IP_RESET, 1'b1));
      offer(make_item(acr_pkg::REQ_LEARN, 32'h0, acr_pkg::MAC_ALL_ONES,
                      acr_pkg::OWN_IP_RESET, 1'b0));
      offer(make_item(acr_pkg::REQ_RESOLVE, 32'h0, 48'h0, 32'h0, 1'b0));
      // A learned broadcast entry does not change what a broadcast resolve returns.
      offer(make_item(acr_pkg::REQ_LEARN, acr_pkg::BCAST_IP, 48'h0000_0000_0001,
                      32'hFFFF_FFFF, 1'b1));
      offer(make_item(acr_pkg::REQ_RESOLVE, acr_pkg::BCAST_IP, 48'h0, 32'h0, 1'b0));
      offer(make_item(acr_pkg::REQ_LEARN, 32'hFFFF_FFFE, 48'h8000_0000_0000,
                      acr_pkg::OWN_IP_RESET ^ 32'h1, 1'b1));
      offer(make_item(acr_pkg::REQ_RESOLVE, 32'hFFFF_FFFE, 48'h0, 32'h0, 1'b0));
      offer(make_item(acr_pkg::REQ_RESOLVE, acr_pkg::OWN_IP_RESET, 48'h0, 32'h0, 1'b0));
      offer(make_item(acr_pkg::REQ_LEARN, acr_pkg::OWN_IP_RESET, 48'hAAAA_AAAA_AAAA,
                      32'h0, 1'b1));
      offer(make_item(acr_pkg::REQ_RESOLVE, acr_pkg::OWN_IP_RESET, 48'h0, 32'h0, 1'b0));
      offer(make_item(acr_pkg::REQ_LEARN, 32'h8000_0000, 48'h5555_5555_5555,
                      acr_pkg::OWN_IP_RESET, 1'b1));
      offer(make_item(acr_pkg::REQ_RESOLVE, 32'h8000_0000, acr_pkg::MAC_ALL_ONES,
                      acr_pkg::OWN_IP_RESET, 1'b1));
      offer(make_item(acr_pkg::REQ_RESOLVE, 32'h0000_0001, 48'h0, 32'h0, 1'b0));
      drain();

      for (int p = 0; p < 5; p++) begin
         if (p != 0)
            write_own_ip(phase_ip[p]);
         // A stalled answer also blocks the request side once the sequencer has finished the next word.
         if (p == 1)
            hold_rsp = 1'b1;
         for (int n = 0; n < PHASE_ITEMS; n++)
            offer(random_item());
         drain();
      end

      repeat (48) @(posedge clock);
      shadow.close_out();
      if (shadow.mismatches == 0)
         $display("arp_cache_learn_resolve_unit: match");
      else
         $display("arp_cache_learn_resolve_unit: mismatch");
      $finish;
   end

endmodule

`default_nettype wire

// File: filelist.f
rtl/acr_pkg.sv
rtl/acr_ifs.sv
rtl/acr_store.sv
rtl/acr_seq.sv
rtl/arp_cache_learn_resolve_unit.sv
sim/tb.sv
